FILE: src/stepper_phase_sequencer_top_assert.svh
// Assertion macros used by the stepper phase sequencer top module.
`ifndef STEPPER_PHASE_SEQUENCER_TOP_ASSERT_SVH
`define STEPPER_PHASE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SPS_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("sps assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SPS_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("sps assertion failed");

`endif

FILE: src/sps_pkg.sv
package sps_pkg;

  // Widths of the internal datapath.
  localparam int STEPS_W   = 20;
  localparam int PHASE_W   = 3;
  localparam int POS_W     = 24;
  localparam int ANGLE_W   = 21;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Input beat and result beat.
  typedef struct packed {
    logic        op;
    logic [15:0] move_degrees;
    logic        clockwise;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]          coils;
    logic [1:0]          status;
    logic [STEPS_W-1:0]  steps_left;
    logic signed [15:0]  angle_deg;
  } out_beat_t;

  // Operation codes.
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_LOADED  = 2'd0;
  localparam logic [1:0] ST_STEPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_LIMIT   = 2'd3;

  // Step modes.
  localparam logic [1:0] MODE_WAVE = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_STEP_MODE = 2'd0;
  localparam logic [1:0] REG_MIN_ANGLE = 2'd1;
  localparam logic [1:0] REG_MAX_ANGLE = 2'd2;

  // Reset values of the registers.
  localparam logic [1:0]        STEP_MODE_RST = MODE_FULL;
  localparam logic signed [15:0] MIN_ANGLE_RST = -16'sd180;
  localparam logic signed [15:0] MAX_ANGLE_RST = 16'sd180;

  // ceil(2^31 / 45); exact floor(x / 45) for any x below 2^25.
  localparam logic [25:0] RECIP_45 = 26'd47721859;

  // Coil drive tables.
  localparam logic [3:0] WAVE_TBL [8] = '{4'h8, 4'h4, 4'h2, 4'h1, 4'h8, 4'h4, 4'h2, 4'h1};
  localparam logic [3:0] FULL_TBL [8] = '{4'hc, 4'h6, 4'h3, 4'h9, 4'hc, 4'h6, 4'h3, 4'h9};
  localparam logic [3:0] HALF_TBL [8] = '{4'h8, 4'hc, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

  // Coil pattern of a phase entry; the unused mode falls back to full step.
  function automatic logic [3:0] coil_pattern(input logic [1:0] mode,
                                              input logic [PHASE_W-1:0] idx);
    logic [3:0] pat;
    case (mode)
      MODE_WAVE: pat = WAVE_TBL[idx];
      MODE_HALF: pat = HALF_TBL[idx];
      default:   pat = FULL_TBL[idx];
    endcase
    return pat;
  endfunction

endpackage

FILE: src/stepper_phase_sequencer_top.sv
// Channel   | Direction | Handshake             | Beat
// ----------+-----------+-----------------------+-----------------------------
// in_       | input     | in_valid / in_ready   | in_beat_t (op, move, cw)
// out_      | output    | out_valid / out_ready | out_beat_t (coils, status...)
// config    | input     | psel/penable/pwrite   | 32-bit registers at 0, 4, 8
//
// Each beat is consumed with the state registers and its result is registered
// at the same edge; a new beat enters every cycle unless out_ready stalls output.
// The critical path is the 16x26 step count multiply or the angle compare.
// in_ready is high whenever the result register is empty or being drained.
// Synchronous active-low reset clears the state, registers and out_valid.
module stepper_phase_sequencer_top
  import sps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration registers.
  logic [1:0]         mode_r;
  logic signed [15:0] min_r;
  logic signed [15:0] max_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  // Motion state.
  logic [STEPS_W-1:0]      steps_r, steps_nxt;
  logic [PHASE_W-1:0]      phase_r, phase_nxt;
  logic                    cw_r, cw_nxt;
  logic signed [POS_W-1:0] pos_r, pos_nxt;

  // Result register.
  logic      out_valid_r;
  out_beat_t out_data_r, out_data_nxt;

  logic                      acc;
  logic signed [POS_W-1:0]   pos_inc, pos_dec;
  logic signed [ANGLE_W-1:0] ang_cur, ang_inc, ang_dec, ang_nxt;
  logic signed [ANGLE_W-1:0] min_ext, max_ext;
  logic                      limit_hit;
  logic [41:0]               cnt_prod;
  logic [STEPS_W-1:0]        cnt_half, cnt_full;
  logic [1:0]                status_nxt;

  // Configuration port: writes in the access phase, reads combinational.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= STEP_MODE_RST;
      min_r  <= MIN_ANGLE_RST;
      max_r  <= MAX_ANGLE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STEP_MODE: mode_r <= pwdata[1:0];
        REG_MIN_ANGLE: min_r  <= pwdata[15:0];
        REG_MAX_ANGLE: max_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STEP_MODE: prdata = {30'd0, mode_r};
      REG_MIN_ANGLE: prdata = {{16{min_r[15]}}, min_r};
      REG_MAX_ANGLE: prdata = {{16{max_r[15]}}, max_r};
      default:       prdata = '0;
    endcase
  end

  // Handshake: the result register frees itself when drained.
  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Angles before and after a step in either direction.
  assign pos_inc = pos_r + POS_W'(1);
  assign pos_dec = pos_r - POS_W'(1);

  sps_angle u_ang_cur (.pos(pos_r),   .angle(ang_cur));
  sps_angle u_ang_inc (.pos(pos_inc), .angle(ang_inc));
  sps_angle u_ang_dec (.pos(pos_dec), .angle(ang_dec));

  assign min_ext   = ANGLE_W'(min_r);
  assign max_ext   = ANGLE_W'(max_r);
  assign limit_hit = (ang_cur <= min_ext) || (ang_cur >= max_ext);

  // Step count: degrees * 512/45 (half step) or * 256/45, by reciprocal.
  assign cnt_prod = 42'(in_data.move_degrees) * 42'(RECIP_45);
  assign cnt_half = cnt_prod[41:22];
  assign cnt_full = {1'b0, cnt_prod[41:23]};

  // Next state and result of the beat on the input.
  always_comb begin
    steps_nxt  = steps_r;
    phase_nxt  = phase_r;
    cw_nxt     = cw_r;
    pos_nxt    = pos_r;
    ang_nxt    = ang_cur;
    status_nxt = ST_EMPTY;
    if (in_data.op == OP_REQUEST) begin
      cw_nxt     = in_data.clockwise;
      steps_nxt  = (mode_r == MODE_HALF) ? cnt_half : cnt_full;
      status_nxt = ST_LOADED;
    end else if (steps_r == '0) begin
      status_nxt = ST_EMPTY;
    end else if (limit_hit) begin
      steps_nxt  = '0;
      status_nxt = ST_LIMIT;
    end else begin
      steps_nxt  = steps_r - STEPS_W'(1);
      status_nxt = ST_STEPPED;
      if (cw_r) begin
        phase_nxt = phase_r + PHASE_W'(1);
        pos_nxt   = pos_inc;
        ang_nxt   = ang_inc;
      end else begin
        phase_nxt = phase_r - PHASE_W'(1);
        pos_nxt   = pos_dec;
        ang_nxt   = ang_dec;
      end
    end
    out_data_nxt.coils      = coil_pattern(mode_r, phase_nxt);
    out_data_nxt.status     = status_nxt;
    out_data_nxt.steps_left = steps_nxt;
    out_data_nxt.angle_deg  = ang_nxt[15:0];
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r     <= '0;
      phase_r     <= '0;
      cw_r        <= 1'b1;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        steps_r <= steps_nxt;
        phase_r <= phase_nxt;
        cw_r    <= cw_nxt;
        pos_r   <= pos_nxt;
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  `include "stepper_phase_sequencer_top_assert.svh"

  // A taken step consumes exactly one step.
  `SPS_ASSERT_NEXT(a_step_consumes, clk, rst_n, acc && (in_data.op == OP_TICK) && (steps_r != '0) && !limit_hit, (steps_r == $past(steps_r) - STEPS_W'(1)) && (out_data.status == ST_STEPPED))

  // A limit stop clears the remaining count and holds the position.
  `SPS_ASSERT_NEXT(a_limit_clears, clk, rst_n, acc && (in_data.op == OP_TICK) && (steps_r != '0) && limit_hit, (steps_r == '0) && (pos_r == $past(pos_r)) && (out_data.status == ST_LIMIT))

  // The phase only ever moves by one entry per beat.
  `SPS_ASSERT_NEXT(a_phase_moves_one, clk, rst_n, acc, (phase_r == $past(phase_r)) || (phase_r == $past(phase_r) + PHASE_W'(1)) || (phase_r == $past(phase_r) - PHASE_W'(1)))

  // An empty result register never blocks the input.
  `SPS_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid_r, in_ready)

endmodule

FILE: src/sps_angle.sv
// Angle in whole degrees from a position in units of 45/512 degree,
// truncated toward zero.
module sps_angle
  import sps_pkg::*;
(
  input  logic signed [POS_W-1:0]   pos,
  output logic signed [ANGLE_W-1:0] angle
);

  localparam int PROD_W = POS_W + 6;

  logic signed [PROD_W-1:0] pos_ext;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;

  // Multiply by 45 as a sum of shifts.
  assign pos_ext = PROD_W'(pos);
  assign prod    = (pos_ext <<< 5) + (pos_ext <<< 3) + (pos_ext <<< 2) + pos_ext;

  // Bias negative values so the shift by nine rounds toward zero.
  assign biased = prod + (pos[POS_W-1] ? PROD_W'(511) : PROD_W'(0));
  assign angle  = biased[PROD_W-1:9];

endmodule
